// ===== src/esc_pkg.sv =====
// Shared types, codes and helpers for the backslash escape decoder.
// No dependencies; every design module refers to this package by scoped names.
package esc_pkg;

  // Width of the saturating decoded-byte counter (at most 16, the width of out_count)
  localparam int COUNT_WIDTH = 16;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Decoder modes
  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESC    = 3'd1;
  localparam logic [2:0] MODE_HEX1   = 3'd2;
  localparam logic [2:0] MODE_HEX2   = 3'd3;
  localparam logic [2:0] MODE_ERR    = 3'd4;

  // Completion status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_ESC  = 3'd1;
  localparam logic [2:0] ST_NO_HEX  = 3'd2;
  localparam logic [2:0] ST_BAD_HEX = 3'd3;
  localparam logic [2:0] ST_UNSUP   = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Flag bit of a digit value that marks a non-hex character
  localparam logic [4:0] BAD_DIGIT = 5'h10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] out_count;
  } res_t;

  // Digit value 0..15, or BAD_DIGIT for anything that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    return BAD_DIGIT;
  endfunction

endpackage

// ===== src/esc_in_if.sv =====
// Input channel of the escape decoder: valid/ready plus one raw byte word.
// No dependencies.
interface esc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, in_byte, is_last, input ready);
  modport sink   (input valid, in_byte, is_last, output ready);
endinterface

// ===== src/esc_out_if.sv =====
// Result channel of the escape decoder: valid/ready plus one result word.
// No dependencies.
interface esc_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        done_res;
  logic [2:0]  status;
  logic [15:0] out_count;

  modport source (output valid, out_valid, out_byte, done_res, status, out_count,
                  input ready);
  modport sink   (input valid, out_valid, out_byte, done_res, status, out_count,
                  output ready);
endinterface

// ===== src/esc_in_stage.sv =====
// Input register of the escape decoder.
// Depends on esc_pkg and esc_in_if.
module esc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  esc_in_if.sink            in_ch,
  input  logic              take_i,
  output logic              valid_o,
  output esc_pkg::in_word_t word_o
);

  logic              valid_r, valid_nxt;
  esc_pkg::in_word_t word_r, word_nxt;
  logic              in_fire;

  assign in_ch.ready = !valid_r || take_i;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (in_fire) begin
      valid_nxt        = 1'b1;
      word_nxt.in_byte = in_ch.in_byte;
      word_nxt.is_last = in_ch.is_last;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

// ===== src/esc_decode.sv =====
// Escape decoding logic and per-string state (mode, high digit, count, error).
// Depends on esc_pkg.
module esc_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  esc_pkg::in_word_t word_i,
  output esc_pkg::res_t     res_o
);

  logic [2:0]                      mode_r, mode_nxt;
  logic [4:0]                      hi_r, hi_nxt;
  logic [esc_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [2:0]                      err_r, err_nxt;
  logic                            emit;
  logic [7:0]                      ob;
  logic [4:0]                      digit;
  logic [7:0]                      c;
  logic                            last;

  assign c     = word_i.in_byte;
  assign last  = word_i.is_last;
  assign digit = esc_pkg::hex_value(c);

  always_comb begin
    mode_nxt = mode_r;
    hi_nxt   = hi_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    ob       = 8'h00;
    case (mode_r)
      esc_pkg::MODE_NORMAL: begin
        if (c == esc_pkg::CH_BSLASH) begin
          if (last) begin
            err_nxt  = esc_pkg::ST_NO_ESC;
            mode_nxt = esc_pkg::MODE_ERR;
          end else begin
            mode_nxt = esc_pkg::MODE_ESC;
          end
        end else begin
          emit = 1'b1;
          ob   = c;
        end
      end
      esc_pkg::MODE_ESC: begin
        mode_nxt = esc_pkg::MODE_NORMAL;
        case (c)
          esc_pkg::CH_BSLASH: begin emit = 1'b1; ob = esc_pkg::CH_BSLASH; end
          esc_pkg::CH_N:      begin emit = 1'b1; ob = esc_pkg::CH_LF; end
          esc_pkg::CH_R:      begin emit = 1'b1; ob = esc_pkg::CH_CR; end
          esc_pkg::CH_T:      begin emit = 1'b1; ob = esc_pkg::CH_TAB; end
          esc_pkg::CH_X: begin
            if (last) begin
              err_nxt  = esc_pkg::ST_NO_HEX;
              mode_nxt = esc_pkg::MODE_ERR;
            end else begin
              mode_nxt = esc_pkg::MODE_HEX1;
            end
          end
          default: begin
            err_nxt  = esc_pkg::ST_UNSUP;
            mode_nxt = esc_pkg::MODE_ERR;
          end
        endcase
      end
      esc_pkg::MODE_HEX1: begin
        hi_nxt = digit;
        if (last) begin
          err_nxt  = esc_pkg::ST_NO_HEX;
          mode_nxt = esc_pkg::MODE_ERR;
        end else begin
          mode_nxt = esc_pkg::MODE_HEX2;
        end
      end
      esc_pkg::MODE_HEX2: begin
        // check both digits only once the second has arrived
        if (hi_r[4] || digit[4]) begin
          err_nxt  = esc_pkg::ST_BAD_HEX;
          mode_nxt = esc_pkg::MODE_ERR;
        end else begin
          emit     = 1'b1;
          ob       = {hi_r[3:0], digit[3:0]};
          mode_nxt = esc_pkg::MODE_NORMAL;
        end
      end
      default: begin
        // error mode and unused codes: drop the byte
      end
    endcase

    cnt_nxt = cnt_r;
    if (emit && cnt_r != esc_pkg::COUNT_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    res_o.out_valid = emit;
    res_o.out_byte  = ob;
    res_o.done_res  = last;
    res_o.status    = last ? err_nxt : esc_pkg::ST_OK;
    res_o.out_count = 16'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esc_pkg::MODE_NORMAL;
      hi_r   <= 5'd0;
      cnt_r  <= '0;
      err_r  <= esc_pkg::ST_OK;
    end else if (fire_i) begin
      if (last) begin
        // end of string: back to the reset state
        mode_r <= esc_pkg::MODE_NORMAL;
        hi_r   <= 5'd0;
        cnt_r  <= '0;
        err_r  <= esc_pkg::ST_OK;
      end else begin
        mode_r <= mode_nxt;
        hi_r   <= hi_nxt;
        cnt_r  <= cnt_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && last |=> mode_r == esc_pkg::MODE_NORMAL && cnt_r == '0 &&
                       err_r == esc_pkg::ST_OK)
    else $error("state not cleared after last word");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && res_o.status != esc_pkg::ST_OK |-> res_o.done_res)
    else $error("status reported before end of string");

  a_drop_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && mode_r == esc_pkg::MODE_ERR |-> !res_o.out_valid)
    else $error("byte emitted in error mode");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != esc_pkg::ST_OK |-> mode_r == esc_pkg::MODE_ERR)
    else $error("error recorded outside error mode");

endmodule

// ===== src/esc_out_stage.sv =====
// Result register of the escape decoder, driving the result channel.
// Depends on esc_pkg and esc_out_if.
module esc_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load_i,
  input  esc_pkg::res_t res_i,
  output logic          free_o,
  esc_out_if.source     out_ch
);

  logic          valid_r, valid_nxt;
  esc_pkg::res_t res_r, res_nxt;

  assign free_o = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load_i) begin
      valid_nxt = 1'b1;
      res_nxt   = res_i;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_valid = res_r.out_valid;
  assign out_ch.out_byte  = res_r.out_byte;
  assign out_ch.done_res  = res_r.done_res;
  assign out_ch.status    = res_r.status;
  assign out_ch.out_count = res_r.out_count;

endmodule

// ===== src/backslash_escape_decoder_top.sv =====
// Backslash escape decoder, top level: input register, decode logic, result register.
// Depends on esc_pkg, esc_in_if, esc_out_if, esc_in_stage, esc_decode, esc_out_stage.
//
// The block takes an escaped string one byte word at a time on in_ch, with
// is_last set on the final byte, and returns exactly one result word on out_ch
// for every input word. A result carries the decoded byte (out_valid set) or
// nothing (the byte was a backslash or part of an escape, or was dropped after
// an error), the running decoded count, and on the last byte the string's
// status and final length. Escapes: backslash-backslash, n, r, t and x with two
// hex digits of either case. Errors: backslash on the last byte, a string that
// ends inside a hex escape, a non-hex digit (judged once both digits are in)
// and any other escape letter; after the first error every byte up to the last
// is dropped and the count stays at its value before the error. The count
// saturates at 2^COUNT_WIDTH-1. Throughput is one word per clock while out_ch does
// not stall: the mode, high digit, count and error registers are updated in the
// same cycle that a word moves from the input register to the result register.
// An accepted word passes through the input register and then the result
// register before its result appears on out_ch, and waits longer only while
// out_ch stalls. State returns to reset after each last byte.
module backslash_escape_decoder_top (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);

  logic              s1_valid;
  esc_pkg::in_word_t s1_word;
  esc_pkg::res_t     res;
  logic              out_free;
  logic              take;

  // advance a held word whenever the result register can take its result
  assign take = s1_valid && out_free;

  esc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take_i  (take),
    .valid_o (s1_valid),
    .word_o  (s1_word)
  );

  esc_decode u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (take),
    .word_i (s1_word),
    .res_o  (res)
  );

  esc_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load_i (take),
    .res_i  (res),
    .free_o (out_free),
    .out_ch (out_ch)
  );

endmodule
